>>> rtl/sges_pkg.sv
// shared types, codes and constants of the gauge servo smoother
package sges_pkg;

    // field widths
    localparam int KIND_W     = 2;
    localparam int SENSOR_W   = 16;
    localparam int REQ_W      = 10;
    localparam int ELAPSED_W  = 16;
    localparam int ANGLE_W    = 8;
    localparam int TAU_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEN_W      = 16;
    localparam int ALPHA_W    = 16;
    localparam int TFRAC_W    = 8;
    localparam int MAP_NUM_W  = 24;

    // fixed values
    localparam int ANGLE_MAX = 180;
    localparam int TAU_MIN   = 50;
    localparam int TAU_MAX   = 5000;
    localparam int X_SPAN    = 10;

    localparam logic signed [SENSOR_W-1:0] RANGE_MIN_RST = 16'sd0;
    localparam logic signed [SENSOR_W-1:0] RANGE_MAX_RST = 16'sd1000;
    localparam logic [TAU_W-1:0]           TAU_RST       = 13'd300;

    localparam logic [ALPHA_W-1:0] TABLE_ONE = 16'hFFFF;

    // q.31 constants for the decay table build
    localparam longint unsigned ONE_Q31    = 64'h0000_0000_8000_0000;
    localparam longint unsigned HALF_Q31   = 64'h0000_0000_4000_0000;
    localparam longint unsigned X_SPAN_Q31 = 64'h0000_0005_0000_0000;
    localparam longint unsigned TABLE_ONE_L = 64'd65535;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_VALUE = 2'd0,
        KIND_SET_ANGLE = 2'd1,
        KIND_DIRECT    = 2'd2,
        KIND_TICK      = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN = 2'd0,
        CFG_RANGE_MAX = 2'd1,
        CFG_TAU       = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD0,
        ST_RD1,
        ST_FSTART,
        ST_MULF,
        ST_ASTART,
        ST_MULA,
        ST_EMIT
    } t_state;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // clamp a signed request into 0..180
    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [REQ_W-1:0] a);
        logic [ANGLE_W-1:0] res;
        if (a < 10'sd0) begin
            res = '0;
        end else if (a > 10'sd180) begin
            res = ANGLE_W'(ANGLE_MAX);
        end else begin
            res = a[ANGLE_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/sges_in_if.sv
// input word channel of the gauge servo smoother
interface sges_in_if;
    import sges_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic signed [SENSOR_W-1:0]  sensor_value;
    logic signed [REQ_W-1:0]     requested_angle;
    logic [ELAPSED_W-1:0]        elapsed_ms;

    modport source (output valid, kind, sensor_value, requested_angle, elapsed_ms,
                    input ready);
    modport sink (input valid, kind, sensor_value, requested_angle, elapsed_ms,
                  output ready);
endinterface

>>> rtl/sges_out_if.sv
// output word channel of the gauge servo smoother
interface sges_out_if;
    import sges_pkg::*;

    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] servo_angle;

    modport source (output valid, servo_angle, input ready);
    modport sink (input valid, servo_angle, output ready);
endinterface

>>> rtl/sges_serial_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module sges_serial_div #(
    parameter int N_W = 25,
    parameter int D_W = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [N_W-1:0]          i_num,
    input  logic [D_W-1:0]          i_den,
    output sges_pkg::t_unit_stat    o_stat,
    output logic [N_W-1:0]          o_quot
);
    import sges_pkg::*;

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_quot;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D_W+1:0]   trial;
    logic             fits;
    logic [D_W-1:0]   n_rem;
    logic [N_W-1:0]   n_quot;

    // shift the next dividend bit into the remainder and try a subtract
    always_comb begin
        trial  = {1'b0, r_rem, r_quot[N_W-1]} - {2'b00, r_den};
        fits   = ~trial[D_W+1];
        n_rem  = fits ? trial[D_W-1:0] : {r_rem[D_W-2:0], r_quot[N_W-1]};
        n_quot = {r_quot[N_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;
endmodule

>>> rtl/sges_serial_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module sges_serial_mul #(
    parameter int A_W = 24,
    parameter int B_W = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [A_W-1:0]          i_a,
    input  logic [B_W-1:0]          i_b,
    output sges_pkg::t_unit_stat    o_stat,
    output logic [A_W+B_W-1:0]      o_prod
);
    import sges_pkg::*;

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_prod;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [A_W:0]       sum;
    logic [A_W+B_W-1:0] n_prod;

    // add the multiplicand on a set lsb, then shift the whole product right
    always_comb begin
        sum    = {1'b0, r_prod[A_W+B_W-1:B_W]} + (r_prod[0] ? {1'b0, r_a} : '0);
        n_prod = {sum, r_prod[B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= n_prod;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_prod;
endmodule

>>> rtl/servo_gauge_ema_smoother.sv
// top level of the gauge servo smoother: target mapping and time-based ema
// order of events: set angle updates the target at the accepting edge; a direct write goes
//   to the emit state and loads the output register once it is free; a set value runs the
//   serial divider (25 bits wide by default), a tick the divider, the table reads and two
//   serial multiplies before its emit state; the block takes one word at a time, and the
//   bit-serial divider and the serial multiplies set the time between tick words
// reset (synchronous, active low): registers to their defaults, target and smoothed angle zero
module servo_gauge_ema_smoother #(
    parameter int DECAY_TABLE_DEPTH = 256,
    parameter int FRAC_BITS         = 16,
    parameter int MAX_STEP_MS       = 500
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sges_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sges_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sges_in_if.sink                             i_in,
    sges_out_if.source                          o_out
);
    import sges_pkg::*;

    // derived sizes
    localparam int IDX_W    = $clog2(DECAY_TABLE_DEPTH);
    localparam int SPAN     = (DECAY_TABLE_DEPTH - 1) * 256;
    localparam int SPAN_W   = $clog2(SPAN + 1);
    localparam int DT_W     = $clog2(MAX_STEP_MS + 1);
    localparam int TICK_W   = DT_W + SPAN_W;
    localparam int N_W      = (TICK_W > MAP_NUM_W) ? TICK_W : MAP_NUM_W;
    localparam int SW       = ANGLE_W + FRAC_BITS;
    localparam int PROD_W   = SW + ALPHA_W;

    typedef logic [ALPHA_W-1:0] t_table [DECAY_TABLE_DEPTH];

    // floor division for the table build, one quotient bit per pass
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // exp(-x) table, x from 0 to 10: taylor series of exp(-x/16) in q1.31,
    // each term truncated, then squared four times; built at elaboration
    function automatic t_table build_table();
        t_table            tab;
        longint unsigned   x;
        longint unsigned   y;
        longint unsigned   term;
        longint unsigned   r;
        longint            sum;
        for (int i = 0; i < DECAY_TABLE_DEPTH; i++) begin
            x    = div_u64(64'(i) * X_SPAN_Q31, 64'(DECAY_TABLE_DEPTH - 1));
            y    = x >> 4;
            sum  = longint'(ONE_Q31);
            term = ONE_Q31;
            for (int k = 1; k <= 16; k++) begin
                term = div_u64((term * y) >> 31, 64'(k));
                if ((k & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = unsigned'(sum);
            if (r > ONE_Q31) begin
                r = ONE_Q31;
            end
            for (int k = 0; k < 4; k++) begin
                r = (r * r) >> 31;
            end
            tab[i] = ALPHA_W'((r * TABLE_ONE_L + HALF_Q31) >> 31);
        end
        return tab;
    endfunction

    localparam t_table DECAY_TABLE = build_table();

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state                     r_state;
    t_state                     n_state;
    logic                       r_tick;
    logic signed [SENSOR_W-1:0] r_range_min;
    logic signed [SENSOR_W-1:0] r_range_max;
    logic [TAU_W-1:0]           r_tau;
    logic [ANGLE_W-1:0]         r_target;
    logic [SW-1:0]              r_smooth;
    logic [IDX_W-1:0]           r_idx;
    logic [TFRAC_W-1:0]         r_frac;
    logic [ALPHA_W-1:0]         r_a0;
    logic [ALPHA_W-1:0]         r_a1;
    logic                       r_up;
    logic                       r_out_valid;
    logic [ANGLE_W-1:0]         r_out_angle;

    // ---------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------
    t_kind                      in_kind;
    logic                       in_ready;
    logic                       in_acc;
    logic [ANGLE_W-1:0]         req_clamped;
    logic                       range_ok;
    logic signed [SENSOR_W-1:0] sensor_clamped;
    logic signed [SENSOR_W:0]   sensor_off;
    logic signed [SENSOR_W:0]   range_span;
    logic [N_W-1:0]             map_num;
    logic [DT_W-1:0]            dt_cap;
    logic [N_W-1:0]             tick_num;
    logic [DEN_W-1:0]           tick_den;
    logic [TAU_W-1:0]           tau_wr;

    assign in_kind     = t_kind'(i_in.kind);
    assign in_acc      = i_in.valid && in_ready;
    assign req_clamped = clamp_angle(i_in.requested_angle);

    // set value: clamp into the range, offset from range_min, times 180
    assign range_ok       = r_range_max > r_range_min;
    assign sensor_clamped = (i_in.sensor_value < r_range_min) ? r_range_min :
                            (i_in.sensor_value > r_range_max) ? r_range_max :
                            i_in.sensor_value;
    assign sensor_off     = (SENSOR_W+1)'(sensor_clamped) - (SENSOR_W+1)'(r_range_min);
    assign range_span     = (SENSOR_W+1)'(r_range_max) - (SENSOR_W+1)'(r_range_min);
    assign map_num        = N_W'(sensor_off[SENSOR_W-1:0]) * N_W'(ANGLE_MAX);

    // tick: table position in q.8 is dt*(depth-1)*256 / (tau*10)
    assign dt_cap   = (i_in.elapsed_ms > ELAPSED_W'(MAX_STEP_MS)) ? DT_W'(MAX_STEP_MS) :
                      DT_W'(i_in.elapsed_ms);
    assign tick_num = N_W'(dt_cap) * N_W'(SPAN);
    assign tick_den = DEN_W'(r_tau * X_SPAN);

    // tau is clamped as it is written
    assign tau_wr = (i_cfg_data[TAU_W-1:0] < TAU_W'(TAU_MIN)) ? TAU_W'(TAU_MIN) :
                    (i_cfg_data[TAU_W-1:0] > TAU_W'(TAU_MAX)) ? TAU_W'(TAU_MAX) :
                    i_cfg_data[TAU_W-1:0];

    // ---------------------------------------------------------------
    // serial units
    // ---------------------------------------------------------------
    t_unit_stat         div_stat;
    logic               div_start;
    logic [N_W-1:0]     div_num;
    logic [DEN_W-1:0]   div_den;
    logic [N_W-1:0]     div_quot;

    t_unit_stat         mul_stat;
    logic               mul_start;
    logic [SW-1:0]      mul_a;
    logic [ALPHA_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;

    sges_serial_div #(
        .N_W (N_W),
        .D_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    sges_serial_mul #(
        .A_W (SW),
        .B_W (ALPHA_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    // ---------------------------------------------------------------
    // tick datapath
    // ---------------------------------------------------------------
    logic               pos_over;
    logic [IDX_W-1:0]   next_idx;
    logic [ALPHA_W-1:0] tab_diff;
    logic [ALPHA_W-1:0] decay_e;
    logic [ALPHA_W-1:0] alpha;
    logic [SW-1:0]      target_q;
    logic               move_up;
    logic [SW-1:0]      smooth_diff;
    logic [SW-1:0]      smooth_step;
    logic [SW:0]        rounded;
    logic [SW-FRAC_BITS:0] whole;
    logic [ANGLE_W-1:0] emit_angle;
    logic               emit_load;

    // positions past the table end take the last entry (frac forced to zero)
    assign pos_over = div_quot >= N_W'(SPAN);
    assign next_idx = (r_idx == IDX_W'(DECAY_TABLE_DEPTH - 1)) ? r_idx : r_idx + 1'b1;

    // linear interpolation between neighbors, table is non-increasing
    assign tab_diff = (r_a0 > r_a1) ? (r_a0 - r_a1) : '0;
    assign decay_e  = r_a0 - ALPHA_W'(mul_prod >> TFRAC_W);
    assign alpha    = TABLE_ONE - decay_e;

    // distance to the target, magnitude only; direction kept in r_up
    assign target_q    = {r_target, {FRAC_BITS{1'b0}}};
    assign move_up     = target_q >= r_smooth;
    assign smooth_diff = move_up ? (target_q - r_smooth) : (r_smooth - target_q);
    assign smooth_step = mul_prod[PROD_W-1:ALPHA_W];

    // round half up, clamp to full scale
    assign rounded    = (SW+1)'(r_smooth) + ((SW+1)'(1) << (FRAC_BITS - 1));
    assign whole      = rounded[SW:FRAC_BITS];
    assign emit_angle = (whole > (SW-FRAC_BITS+1)'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) :
                        whole[ANGLE_W-1:0];

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_kind)
                        KIND_SET_VALUE: n_state = range_ok ? ST_DIV : ST_IDLE;
                        KIND_SET_ANGLE: n_state = ST_IDLE;
                        KIND_DIRECT:    n_state = ST_EMIT;
                        KIND_TICK:      n_state = ST_DIV;
                        default:        n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = r_tick ? ST_RD0 : ST_IDLE;
                end
            end
            ST_RD0:    n_state = ST_RD1;
            ST_RD1:    n_state = ST_FSTART;
            ST_FSTART: n_state = ST_MULF;
            ST_MULF: begin
                if (mul_stat.done) begin
                    n_state = ST_ASTART;
                end
            end
            ST_ASTART: n_state = ST_MULA;
            ST_MULA: begin
                if (mul_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register to be free
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        in_ready  = (r_state == ST_IDLE);
        div_start = 1'b0;
        div_num   = map_num;
        div_den   = range_span[DEN_W-1:0];
        mul_start = 1'b0;
        mul_a     = SW'(tab_diff);
        mul_b     = ALPHA_W'(r_frac);
        emit_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_kind == KIND_TICK) begin
                    div_num = tick_num;
                    div_den = tick_den;
                end
                div_start = in_acc && ((in_kind == KIND_TICK) ||
                                       (in_kind == KIND_SET_VALUE && range_ok));
            end
            ST_FSTART: begin
                mul_start = 1'b1;
            end
            ST_ASTART: begin
                mul_start = 1'b1;
                mul_a     = smooth_diff;
                mul_b     = alpha;
            end
            ST_EMIT: begin
                emit_load = !r_out_valid || o_out.ready;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control and architectural state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_range_min <= RANGE_MIN_RST;
            r_range_max <= RANGE_MAX_RST;
            r_tau       <= TAU_RST;
            r_target    <= '0;
            r_smooth    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RANGE_MIN: r_range_min <= i_cfg_data;
                    CFG_RANGE_MAX: r_range_max <= i_cfg_data;
                    CFG_TAU:       r_tau       <= tau_wr;
                    default:       r_tau       <= r_tau;
                endcase
            end

            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_acc) begin
                case (in_kind)
                    KIND_SET_VALUE: begin
                        if (!range_ok) begin
                            r_target <= '0;
                        end
                    end
                    KIND_SET_ANGLE: r_target <= req_clamped;
                    KIND_DIRECT: begin
                        // snap both target and smoothed angle
                        r_target <= req_clamped;
                        r_smooth <= {req_clamped, {FRAC_BITS{1'b0}}};
                    end
                    default: r_target <= r_target;
                endcase
            end

            // mapped target is the low byte of the quotient (at most 180)
            if (r_state == ST_DIV && div_stat.done && !r_tick) begin
                r_target <= div_quot[ANGLE_W-1:0];
            end

            if (r_state == ST_MULA && mul_stat.done) begin
                r_smooth <= r_up ? (r_smooth + smooth_step) : (r_smooth - smooth_step);
            end
        end
    end

    // ---------------------------------------------------------------
    // work registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tick <= (in_kind == KIND_TICK);
        end
        if (r_state == ST_DIV && div_stat.done) begin
            r_idx  <= pos_over ? IDX_W'(DECAY_TABLE_DEPTH - 1) : IDX_W'(div_quot >> TFRAC_W);
            r_frac <= pos_over ? '0 : div_quot[TFRAC_W-1:0];
        end
        if (r_state == ST_RD0) begin
            r_a0 <= DECAY_TABLE[r_idx];
        end
        if (r_state == ST_RD1) begin
            r_a1 <= DECAY_TABLE[next_idx];
        end
        if (r_state == ST_ASTART) begin
            r_up <= move_up;
        end
        if (emit_load) begin
            r_out_angle <= emit_angle;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.servo_angle = r_out_angle;

`ifndef SYNTHESIS
    // no serial unit runs while the block waits for a word
    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!div_stat.busy && !mul_stat.busy))
        else $error("serial unit busy in idle");

    // a multiply finishes only where the sequencer waits for it
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> (r_state == ST_MULF || r_state == ST_MULA))
        else $error("multiply done outside a wait state");

    // a divide finishes only in the divide state
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DIV))
        else $error("divide done outside the divide state");

    // a direct write goes straight to the output stage
    a_direct_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_kind == KIND_DIRECT) |=> (r_state == ST_EMIT))
        else $error("direct write did not reach the output stage");
`endif
endmodule

>>> verif/tb_servo_gauge_ema_smoother.sv
// self-checking testbench of the gauge servo smoother with its own angle predictor
module tb_servo_gauge_ema_smoother;
    import sges_pkg::*;

    // build of the block under test, kept at its defaults
    localparam int LUT_DEPTH = 256;
    localparam int FRAC      = 16;
    localparam int STEP_CAP  = 500;

    localparam longint unsigned LUT_SPAN = longint'(LUT_DEPTH - 1) * 256;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_WORDS   = 150;
    localparam int REPORT_MAX    = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sges_in_if  in_if ();
    sges_out_if out_if ();

    servo_gauge_ema_smoother u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor state: registers, target, q8.16 smoothed angle and the decay table
    logic signed [SENSOR_W-1:0] cfg_lo;
    logic signed [SENSOR_W-1:0] cfg_hi;
    logic [TAU_W-1:0]           cfg_tau;
    logic [ANGLE_W-1:0]         st_target;
    logic [ANGLE_W+FRAC-1:0]    st_smooth;
    logic [15:0]                decay_lut [LUT_DEPTH];

    // servo angles predicted and not yet seen at the output
    logic [ANGLE_W-1:0] angle_due [$];

    // bookkeeping
    int  cycle_cnt;
    int  mismatch_cnt;
    int  angles_checked;
    int  reg_writes;
    int  kind_cnt [4];
    int  hold_requests;
    bit  quiet;

    // --------------------------------------------------------------------------------
    // predictor
    // --------------------------------------------------------------------------------

    // exp(-x_i) in q0.16 for table entry i: series of exp(-x/16) in q1.31, squared four times
    function automatic logic [15:0] decay_entry(input int i);
        longint unsigned x, y, term, r;
        longint          acc;
        x = (longint'(i) * X_SPAN * ONE_Q31) / longint'(LUT_DEPTH - 1);
        y = x >> 4;
        acc = longint'(ONE_Q31);
        term = ONE_Q31;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * y) >> 31) / longint'(k);
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        r = longint'(acc);
        if (r > ONE_Q31) begin
            r = ONE_Q31;
        end
        repeat (4) r = (r * r) >> 31;
        return 16'((r * 65535 + (64'd1 << 30)) >> 31);
    endfunction

    function automatic logic [ANGLE_W-1:0] limit_angle(input logic signed [REQ_W-1:0] a);
        if (a < 0) begin
            return '0;
        end else if (a > ANGLE_MAX) begin
            return ANGLE_W'(ANGLE_MAX);
        end
        return a[ANGLE_W-1:0];
    endfunction

    task automatic reset_model();
        cfg_lo    = RANGE_MIN_RST;
        cfg_hi    = RANGE_MAX_RST;
        cfg_tau   = TAU_RST;
        st_target = '0;
        st_smooth = '0;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            decay_lut[i] = decay_entry(i);
        end
    endtask

    // register write as the block sees it; tau is masked to 13 bits then clamped
    task automatic model_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        logic [TAU_W-1:0] t;
        case (idx)
            CFG_RANGE_MIN: cfg_lo = data;
            CFG_RANGE_MAX: cfg_hi = data;
            CFG_TAU: begin
                t = data[TAU_W-1:0];
                if (t < TAU_MIN) t = TAU_W'(TAU_MIN);
                if (t > TAU_MAX) t = TAU_W'(TAU_MAX);
                cfg_tau = t;
            end
            default: ;  // unknown index leaves everything as it was
        endcase
    endtask

    // updates target and smoothed angle for one accepted word, queues the angle it emits
    task automatic predict_servo_word(input t_kind k, input logic signed [SENSOR_W-1:0] sv,
                                      input logic signed [REQ_W-1:0] ra,
                                      input logic [ELAPSED_W-1:0] em);
        longint          lo, hi, c;
        longint unsigned dt, pos, p, f, a0, a1, d, e, alpha, tq, sm, ang;
        lo = cfg_lo;
        hi = cfg_hi;
        case (k)
            KIND_SET_VALUE: begin
                // empty range maps everything to zero
                if (hi <= lo) begin
                    st_target = '0;
                end else begin
                    c = sv;
                    if (c < lo) c = lo;
                    if (c > hi) c = hi;
                    st_target = ANGLE_W'(((c - lo) * ANGLE_MAX) / (hi - lo));
                end
            end
            KIND_SET_ANGLE: st_target = limit_angle(ra);
            KIND_DIRECT: begin
                st_target = limit_angle(ra);
                st_smooth = {st_target, FRAC'(0)};
                angle_due.push_back(st_target);
            end
            default: begin
                dt = em;
                if (dt > STEP_CAP) dt = STEP_CAP;
                // table position in q.8 of dt/tau scaled onto the table span
                pos = (dt * LUT_SPAN) / (longint'(cfg_tau) * X_SPAN);
                if (pos >= LUT_SPAN) begin
                    e = decay_lut[LUT_DEPTH-1];
                end else begin
                    p  = pos >> 8;
                    f  = pos & 255;
                    a0 = decay_lut[p];
                    a1 = decay_lut[p+1];
                    d  = (a0 > a1) ? (a0 - a1) : 0;
                    e  = a0 - ((d * f) >> 8);
                end
                alpha = 65535 - e;
                tq = longint'(st_target) << FRAC;
                sm = st_smooth;
                // alpha is q0.16, step magnitude truncated
                if (tq >= sm) begin
                    sm = sm + ((alpha * (tq - sm)) >> 16);
                end else begin
                    sm = sm - ((alpha * (sm - tq)) >> 16);
                end
                st_smooth = (ANGLE_W+FRAC)'(sm);
                ang = (sm + (64'd1 << (FRAC - 1))) >> FRAC;
                if (ang > ANGLE_MAX) ang = ANGLE_MAX;
                angle_due.push_back(ANGLE_W'(ang));
            end
        endcase
    endtask

    // --------------------------------------------------------------------------------
    // drivers
    // --------------------------------------------------------------------------------

    // mostly back to back, sometimes a few cycles, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offers one word after a random gap and predicts it once accepted
    task automatic send_word(input t_kind k, input logic signed [SENSOR_W-1:0] sv,
                             input logic signed [REQ_W-1:0] ra,
                             input logic [ELAPSED_W-1:0] em);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid           = 1'b1;
        in_if.kind            = k;
        in_if.sensor_value    = sv;
        in_if.requested_angle = ra;
        in_if.elapsed_ms      = em;
        do @(posedge i_clk); while (!in_if.ready);
        kind_cnt[k]++;
        predict_servo_word(k, sv, ra, em);
    endtask

    // drop valid, drain every expected angle, then give a silent set value time to finish
    task automatic settle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (angle_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        model_reg_write(idx, data);
        reg_writes++;
    endtask

    // output side: random stalls, plus long hold-offs on request
    initial begin : angle_sink
        int stall_left;
        int holds_served;
        out_if.ready = 1'b0;
        stall_left   = 0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served < hold_requests) begin
                holds_served++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left   = pick_gap();
                out_if.ready = (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    // --------------------------------------------------------------------------------
    // checker: every accepted angle against the oldest prediction
    // --------------------------------------------------------------------------------
    logic [ANGLE_W-1:0] want_angle;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (angle_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX) begin
                    $display("servo angle %0d arrived with nothing expected", out_if.servo_angle);
                end
            end else begin
                want_angle = angle_due.pop_front();
                angles_checked++;
                if (out_if.servo_angle !== want_angle) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX) begin
                        $display("servo angle %0d: expected %0d, got %0d", angles_checked,
                                 want_angle, out_if.servo_angle);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d angles still expected", cycle_cnt,
                 angle_due.size());
        $display("** servo_gauge_ema_smoother: FAILED **");
        $finish;
    end

    // --------------------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------------------

    // default registers: snap extremes, clamped angles, sensor extremes, tick lengths
    task automatic test_directed_words();
        send_word(KIND_TICK,      $urandom, $urandom, 16'd0);     // zero elapsed from reset
        send_word(KIND_DIRECT,    $urandom, -10'sd512, $urandom);
        send_word(KIND_DIRECT,    $urandom, 10'sd511, $urandom);
        send_word(KIND_TICK,      $urandom, $urandom, 16'd0);     // angle repeated
        send_word(KIND_SET_ANGLE, $urandom, -10'sd1, $urandom);
        send_word(KIND_TICK,      $urandom, $urandom, 16'hFFFF);  // capped step
        send_word(KIND_SET_ANGLE, $urandom, 10'sd181, $urandom);
        send_word(KIND_TICK,      $urandom, $urandom, 16'd1);
        send_word(KIND_SET_VALUE, -16'sd32768, $urandom, $urandom);
        send_word(KIND_TICK,      $urandom, $urandom, 16'd300);
        send_word(KIND_SET_VALUE, 16'sd32767, $urandom, $urandom);
        send_word(KIND_TICK,      $urandom, $urandom, 16'd500);
        send_word(KIND_DIRECT,    $urandom, 10'sd180, $urandom);
        send_word(KIND_DIRECT,    $urandom, 10'sd0, $urandom);
        settle();
    endtask

    // register corners: tau clamps, ratio past the table, empty and full ranges, bad index
    task automatic test_register_corners();
        write_reg(CFG_TAU, 16'h0000);                   // clamps up to the minimum
        send_word(KIND_SET_ANGLE, $urandom, 10'sd180, $urandom);
        send_word(KIND_TICK, $urandom, $urandom, 16'd500);   // dt/tau of ten, last entry
        send_word(KIND_TICK, $urandom, $urandom, 16'hFFFF);
        settle();
        write_reg(CFG_UNUSED, 16'h0FA0);                // must leave tau alone
        send_word(KIND_SET_ANGLE, $urandom, 10'sd0, $urandom);
        send_word(KIND_TICK, $urandom, $urandom, 16'd7);
        settle();
        write_reg(CFG_RANGE_MIN, 16'sd5);               // empty range, equal bounds
        write_reg(CFG_RANGE_MAX, 16'sd5);
        write_reg(CFG_TAU, 16'hFFFF);                   // masked, then clamped to the maximum
        send_word(KIND_DIRECT, $urandom, 10'sd90, $urandom);
        send_word(KIND_SET_VALUE, 16'sd100, $urandom, $urandom);
        send_word(KIND_TICK, $urandom, $urandom, 16'd500);
        settle();
        write_reg(CFG_RANGE_MIN, 16'sh7FFF);            // full span of the sensor
        write_reg(CFG_RANGE_MAX, 16'sh8000);
        write_reg(CFG_RANGE_MIN, 16'sh8000);
        write_reg(CFG_RANGE_MAX, 16'sh7FFF);
        send_word(KIND_SET_VALUE, 16'sd0, $urandom, $urandom);
        send_word(KIND_TICK, $urandom, $urandom, 16'd250);
        send_word(KIND_SET_VALUE, 16'sh7FFF, $urandom, $urandom);
        send_word(KIND_TICK, $urandom, $urandom, 16'd1);
        settle();
    endtask

    task automatic pick_random_config();
        int r, a, b;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            a = -32768;
            b = 32767;
        end else if (r == 1) begin
            // empty range, max at or below min
            a = int'($urandom_range(0, 65535)) - 32768;
            b = a - int'($urandom_range(0, 500));
            if (b < -32768) b = -32768;
        end else if (r == 2) begin
            a = int'($urandom_range(0, 65535)) - 32768;
            b = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            a = int'($urandom_range(0, 4000)) - 2000;
            b = a + int'($urandom_range(1, 3000));
        end
        write_reg(CFG_RANGE_MIN, CFG_DATA_W'(a));
        write_reg(CFG_RANGE_MAX, CFG_DATA_W'(b));
        r = $urandom_range(0, 9);
        if (r == 0) begin
            write_reg(CFG_TAU, CFG_DATA_W'($urandom));
        end else if (r == 1) begin
            write_reg(CFG_TAU, CFG_DATA_W'(TAU_MIN));
        end else if (r == 2) begin
            write_reg(CFG_TAU, CFG_DATA_W'(TAU_MAX));
        end else if (r == 3) begin
            write_reg(CFG_TAU, CFG_DATA_W'($urandom_range(0, TAU_MIN - 1)));
        end else begin
            write_reg(CFG_TAU, CFG_DATA_W'($urandom_range(TAU_MIN, 1500)));
        end
    endtask

    // one random word, values mostly where the current range and angles make sense
    task automatic send_random_word();
        int                    r, s, span;
        t_kind                 k;
        logic [SENSOR_W-1:0]   sv;
        logic [REQ_W-1:0]      ra;
        logic [ELAPSED_W-1:0]  em;
        sv = $urandom;
        ra = $urandom;
        em = $urandom;
        r = $urandom_range(0, 99);
        if (r < 25) k = KIND_SET_VALUE;
        else if (r < 45) k = KIND_SET_ANGLE;
        else if (r < 60) k = KIND_DIRECT;
        else k = KIND_TICK;
        if ($urandom_range(0, 9) < 8) begin
            span = int'(cfg_hi) - int'(cfg_lo);
            if (span <= 0) span = 200;
            s = int'(cfg_lo) - 50 + int'($urandom_range(0, span + 100));
            if (s < -32768) s = -32768;
            if (s > 32767) s = 32767;
            sv = SENSOR_W'(s);
        end
        if ($urandom_range(0, 9) < 8) begin
            ra = REQ_W'($urandom_range(0, ANGLE_MAX));
        end
        r = $urandom_range(0, 99);
        if (r < 5) em = '0;
        else if (r < 70) em = ELAPSED_W'($urandom_range(0, 40));
        else if (r < 85) em = ELAPSED_W'($urandom_range(41, 600));
        send_word(k, sv, ra, em);
    endtask

    // several phases of random words, each under fresh registers, one without any idling
    task automatic test_random_traffic();
        for (int ph = 0; ph < 6; ph++) begin
            quiet = (ph == 3);
            pick_random_config();
            repeat (PHASE_WORDS) send_random_word();
            settle();
        end
        quiet = 1'b0;
    endtask

    // output held off for a long stretch while words keep coming, block must stall its input
    task automatic test_output_hold_off();
        quiet = 1'b1;
        write_reg(CFG_TAU, CFG_DATA_W'(TAU_MIN));
        hold_requests++;
        repeat (24) send_random_word();
        quiet = 1'b0;
        settle();
    endtask

    initial begin : main
        int leftover;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_RANGE_MIN;
        cfg_data              = '0;
        in_if.valid           = 1'b0;
        in_if.kind            = KIND_SET_VALUE;
        in_if.sensor_value    = '0;
        in_if.requested_angle = '0;
        in_if.elapsed_ms      = '0;
        mismatch_cnt          = 0;
        angles_checked        = 0;
        reg_writes            = 0;
        hold_requests         = 0;
        quiet                 = 1'b0;
        kind_cnt              = '{default: 0};
        reset_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_words();
        test_register_corners();
        test_random_traffic();
        test_output_hold_off();
        settle();

        leftover = angle_due.size();
        $display("run covered %0d words: %0d set value, %0d set angle, %0d direct, %0d tick;",
                 kind_cnt[0] + kind_cnt[1] + kind_cnt[2] + kind_cnt[3], kind_cnt[KIND_SET_VALUE],
                 kind_cnt[KIND_SET_ANGLE], kind_cnt[KIND_DIRECT], kind_cnt[KIND_TICK]);
        $display("%0d register writes, %0d angles checked, %0d mismatches, %0d output hold-offs",
                 reg_writes, angles_checked, mismatch_cnt, hold_requests);
        if (mismatch_cnt == 0 && leftover == 0) begin
            $display("** servo_gauge_ema_smoother: PASSED **");
        end else begin
            $display("** servo_gauge_ema_smoother: FAILED **");
        end
        $finish;
    end

endmodule

>>> servo_gauge_ema_smoother.f
rtl/sges_pkg.sv
rtl/sges_in_if.sv
rtl/sges_out_if.sv
rtl/sges_serial_div.sv
rtl/sges_serial_mul.sv
rtl/servo_gauge_ema_smoother.sv
verif/tb_servo_gauge_ema_smoother.sv
